/* rtl/csvt_pkg.sv */
package csvt_pkg;

  localparam logic [7:0] QUOTE_CHAR     = 8'h22;
  localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [7:0] CR_CHAR        = 8'h0D;
  localparam logic [7:0] DELIMITER_RST  = 8'd44;

  // Configuration address space: 32-bit registers at byte address 4*i.
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0]  REG_DELIMITER = 1'b0;

  // One result word of the tokenizer.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       data_valid;
    logic       field_end;
    logic       row_end;
  } csvt_res_t;

endpackage

/* rtl/csvt_cfg.sv */
module csvt_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csvt_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [7:0]                   delimiter_o
);
  import csvt_pkg::*;

  logic [7:0] delimiter_q;
  logic [7:0] delimiter_d;
  logic       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1] == REG_DELIMITER);

  always_comb begin
    delimiter_d = delimiter_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      delimiter_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q <= DELIMITER_RST;
    end else begin
      delimiter_q <= delimiter_d;
    end
  end

  assign prdata      = reg_hit ? {24'd0, delimiter_q} : 32'd0;
  assign delimiter_o = delimiter_q;

endmodule

/* rtl/csvt_core.sv */
module csvt_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_input_i,
  input  logic [7:0]         delimiter_i,
  output csvt_pkg::csvt_res_t res_o
);
  import csvt_pkg::*;

  logic [7:0] held_byte_q, held_byte_d;
  logic       held_valid_q, held_valid_d;
  logic [1:0] kept_count_q, kept_count_d;
  logic       in_quotes_q, in_quotes_d;
  logic       quote_odd_q, quote_odd_d;
  logic       prev_quote_q, prev_quote_d;
  logic       field_seen_q, field_seen_d;

  logic [7:0] c;
  logic       is_quote;
  logic       term;
  logic       carry;

  always_comb begin
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    kept_count_d = kept_count_q;
    in_quotes_d  = in_quotes_q;
    quote_odd_d  = quote_odd_q;
    prev_quote_d = prev_quote_q;
    field_seen_d = field_seen_q;
    res_o        = '0;
    c            = end_of_input_i ? NEWLINE_CHAR : in_byte_i;
    is_quote     = (c == QUOTE_CHAR);
    term         = 1'b0;
    carry        = 1'b0;

    if (end_of_input_i && (kept_count_q == 2'd0) && !field_seen_q) begin
      // End of text with nothing pending: drop the row state silently.
      held_byte_d  = '0;
      held_valid_d = 1'b0;
      kept_count_d = '0;
      in_quotes_d  = 1'b0;
      quote_odd_d  = 1'b0;
      prev_quote_d = 1'b0;
      field_seen_d = 1'b0;
    end else if (!end_of_input_i && (c == CR_CHAR)) begin
      // Carriage returns are skipped entirely.
    end else if ((kept_count_q == 2'd0) && !prev_quote_q && is_quote) begin
      // Quote at field start opens quoting.
      in_quotes_d  = 1'b1;
      prev_quote_d = 1'b1;
    end else begin
      if (!((kept_count_q == 2'd0) && !prev_quote_q)) begin
        if (is_quote) begin
          quote_odd_d = !quote_odd_q;
          in_quotes_d = quote_odd_q;
          // Second quote of a pair retracts the first one.
          if (quote_odd_q && (kept_count_q != 2'd0)) begin
            kept_count_d = kept_count_q - 2'd1;
            held_valid_d = 1'b0;
          end
        end else begin
          quote_odd_d = 1'b0;
        end
      end

      term  = end_of_input_i ||
              (((c == delimiter_i) || (c == NEWLINE_CHAR)) && !in_quotes_d);
      carry = held_valid_d && !prev_quote_q;

      if (term) begin
        res_o.valid      = 1'b1;
        res_o.data       = carry ? held_byte_q : 8'd0;
        res_o.data_valid = carry;
        res_o.field_end  = 1'b1;
        res_o.row_end    = (c == NEWLINE_CHAR);
        held_byte_d      = '0;
        held_valid_d     = 1'b0;
        kept_count_d     = '0;
        in_quotes_d      = 1'b0;
        if (c == NEWLINE_CHAR) begin
          quote_odd_d  = 1'b0;
          prev_quote_d = 1'b0;
          field_seen_d = 1'b0;
        end else begin
          prev_quote_d = is_quote;
          field_seen_d = 1'b1;
        end
      end else begin
        if (held_valid_d) begin
          res_o.valid      = 1'b1;
          res_o.data       = held_byte_q;
          res_o.data_valid = 1'b1;
        end
        held_byte_d  = c;
        held_valid_d = 1'b1;
        if (kept_count_d != 2'd2) begin
          kept_count_d = kept_count_d + 2'd1;
        end
        prev_quote_d = is_quote;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      kept_count_q <= '0;
      in_quotes_q  <= 1'b0;
      quote_odd_q  <= 1'b0;
      prev_quote_q <= 1'b0;
      field_seen_q <= 1'b0;
    end else if (step_en_i) begin
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      kept_count_q <= kept_count_d;
      in_quotes_q  <= in_quotes_d;
      quote_odd_q  <= quote_odd_d;
      prev_quote_q <= prev_quote_d;
      field_seen_q <= field_seen_d;
    end
  end

endmodule

/* rtl/csv_field_tokenizer.sv */
// CSV field tokenizer.
// Input channel: one text byte per word (in_byte_i, end_of_input_i) under
// in_valid_i / in_stall_o. A word with end_of_input_i set closes the text and
// its byte is ignored. Output channel: one result word (content byte with its
// valid flag, field end, row end) under out_valid_o / out_stall_i. Many input
// words give no result word at all (carriage returns, opening quotes, the
// first byte of a field, which is held back one word).
// An accepted word is captured in the input register and processed from there
// into the output register once that register is free or being emptied, and
// its result stays on the outputs until the receiver takes it. Both registers
// advance together, which keeps the throughput at one word per cycle as long
// as the receiver does not stall.
// When the receiver stalls, the output register holds its word, the input
// register fills, and in_stall_o rises until the output word is taken.
// Reset empties both registers, clears all field and quoting state and sets
// the delimiter to a comma. The delimiter is written through the APB port at
// byte address 0 and should only be changed while the block is idle.
module csv_field_tokenizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   in_byte_i,
  input  logic                         end_of_input_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         out_byte_valid_o,
  output logic                         field_end_o,
  output logic                         row_end_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csvt_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import csvt_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;
  logic       advance;
  logic [7:0] delimiter;
  csvt_res_t  res;
  csvt_res_t  out_q;

  csvt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .delimiter_o (delimiter)
  );

  // The input word is processed when the output register is free or being
  // emptied in this cycle.
  assign advance    = in_valid_q && (!out_q.valid || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  csvt_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (advance),
    .in_byte_i      (in_byte_q),
    .end_of_input_i (in_eoi_q),
    .delimiter_i    (delimiter),
    .res_o          (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
      in_eoi_q  <= end_of_input_i;
    end
  end

  // Output register: loaded on every processed word, emptied when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (advance) begin
      out_q <= res;
    end else if (!out_stall_i) begin
      out_q.valid <= 1'b0;
    end
  end

  assign out_valid_o      = out_q.valid;
  assign out_byte_o       = out_q.data;
  assign out_byte_valid_o = out_q.data_valid;
  assign field_end_o      = out_q.field_end;
  assign row_end_o        = out_q.row_end;

  // The input side may only stall while a word waits in the input register.
  a_stall_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  // A row end is always also a field end.
  a_row_end_closes_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && row_end_o) |-> field_end_o)
    else $error("row end without field end");

  // A result word always carries something.
  a_result_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_byte_valid_o || field_end_o))
    else $error("empty result word");

  // A word that is stalled at the output stays in place.
  a_out_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_byte_o)))
    else $error("stalled output word changed");

endmodule
